// File: sv/ctt_pkg.sv
// Shared constants and types for the coordinate tag table.
`default_nettype none
package ctt_pkg;

  localparam int SLOTS     = 64;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CTR_W     = $clog2(SLOTS + 1);
  localparam int KEY_W     = 22;
  localparam int RAD_W     = 10;
  localparam int R2_W      = 2 * RAD_W;
  localparam int DX_W      = KEY_W + 1;
  localparam int SQ_W      = 2 * KEY_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int KIND_W    = 2;
  localparam int SLOT_W    = 6;
  localparam int COUNT_W   = 7;
  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(8);

  typedef enum logic [KIND_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_EVICT  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Slot index travelling down the scan pipeline.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic far;
    logic busy;
  } dist_status_t;

endpackage
`default_nettype wire

// File: sv/ctt_coord_mem.sv
// Coordinate store: one write port, one registered read port.
`default_nettype none
module ctt_coord_mem (
  input  logic                              clk,
  input  logic                              we,
  input  logic [ctt_pkg::IDX_W-1:0]         waddr,
  input  logic signed [ctt_pkg::KEY_W-1:0]  wx,
  input  logic signed [ctt_pkg::KEY_W-1:0]  wz,
  input  logic                              re,
  input  logic [ctt_pkg::IDX_W-1:0]         raddr,
  output logic signed [ctt_pkg::KEY_W-1:0]  rx,
  output logic signed [ctt_pkg::KEY_W-1:0]  rz
);
  import ctt_pkg::*;

  logic signed [KEY_W-1:0] mem_x [SLOTS];
  logic signed [KEY_W-1:0] mem_z [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_z[waddr] <= wz;
    end
    if (re) begin
      rx <= mem_x[raddr];
      rz <= mem_z[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/ctt_dist.sv
// Pipelined squared-distance check against the keep radius.
`default_nettype none
module ctt_dist (
  input  logic                              clk,
  input  logic                              rst,
  input  ctt_pkg::tag_t                     tag_in,
  input  logic signed [ctt_pkg::KEY_W-1:0]  rx,
  input  logic signed [ctt_pkg::KEY_W-1:0]  rz,
  input  logic signed [ctt_pkg::KEY_W-1:0]  kx,
  input  logic signed [ctt_pkg::KEY_W-1:0]  kz,
  input  logic [ctt_pkg::R2_W-1:0]          r2,
  output ctt_pkg::dist_status_t             status
);
  import ctt_pkg::*;

  tag_t                   tag_a;
  tag_t                   tag_b;
  logic signed [DX_W-1:0] dx;
  logic signed [DX_W-1:0] dz;
  logic [SQ_W-1:0]        sqx;
  logic [SQ_W-1:0]        sqz;
  logic signed [2*DX_W-1:0] prod_x;
  logic signed [2*DX_W-1:0] prod_z;
  logic [SUM_W-1:0]       dsum;

  assign prod_x = dx * dx;
  assign prod_z = dz * dz;
  assign dsum   = {1'b0, sqx} + {1'b0, sqz};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a.vld <= 1'b0;
      tag_b.vld <= 1'b0;
    end else begin
      tag_a.vld <= tag_in.vld;
      tag_b.vld <= tag_a.vld;
    end
    tag_a.idx <= tag_in.idx;
    tag_b.idx <= tag_a.idx;
    dx  <= {rx[KEY_W-1], rx} - {kx[KEY_W-1], kx};
    dz  <= {rz[KEY_W-1], rz} - {kz[KEY_W-1], kz};
    // |d| < 2^22, so the square fits in 44 bits
    sqx <= prod_x[SQ_W-1:0];
    sqz <= prod_z[SQ_W-1:0];
  end

  assign status.tag  = tag_b;
  assign status.far  = tag_b.vld && (dsum > SUM_W'(r2));
  assign status.busy = tag_a.vld || tag_b.vld;

endmodule
`default_nettype wire

// File: sv/coordinate_tag_table_with_radius_evict.sv
// Fully associative 2-D coordinate tag table with radius eviction.
// Input channel (in_valid/in_ready) carries kind, key_x, key_z; kind 0 looks
// up the lowest valid slot holding the key, 1 allocates the lowest free slot,
// 2 evicts every slot farther than cache_radius from the key, 3 does nothing.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// found, slot_index, evicted_count and loaded_count after the item.
// One item is in work at a time. Lookup and evict read the coordinate memory
// one slot per cycle through its single read port; allocate walks the valid
// bits one slot per cycle, and kind 3 goes straight to its result.
// The user must write cache_radius with cfg_we/cfg_data only while the
// block is idle; the block does not enforce this. Reset clears all valid
// bits and the loaded count and sets the radius to 8; coordinates are not
// cleared, and all slots are read in a scan but only valid ones are used.
// A result waits in the output register while out_ready is low; the block
// then holds the next result until that register is free, and in_ready stays
// low only while an item is in work.
`default_nettype none
module coordinate_tag_table_with_radius_evict (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ctt_pkg::RAD_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ctt_pkg::KIND_W-1:0]         kind,
  input  logic signed [ctt_pkg::KEY_W-1:0]   key_x,
  input  logic signed [ctt_pkg::KEY_W-1:0]   key_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [ctt_pkg::SLOT_W-1:0]         slot_index,
  output logic [ctt_pkg::COUNT_W-1:0]        evicted_count,
  output logic [ctt_pkg::COUNT_W-1:0]        loaded_count
);
  import ctt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ALLOC, S_SCAN, S_FIN} state_t;

  state_t                  state;
  op_t                     op;
  logic [RAD_W-1:0]        cache_radius;
  logic [R2_W-1:0]         r2;
  logic signed [KEY_W-1:0] kx;
  logic signed [KEY_W-1:0] kz;
  logic [CTR_W-1:0]        iss;
  logic [SLOTS-1:0]        slot_valid;
  logic [CTR_W-1:0]        loaded_total;
  logic                    res_found;
  logic [IDX_W-1:0]        res_slot;
  logic [CTR_W-1:0]        res_evicted;
  tag_t                    tag1;

  logic                    scan_end;
  logic [IDX_W-1:0]        cur_idx;
  logic                    mem_we;
  logic                    mem_re;
  logic signed [KEY_W-1:0] rx;
  logic signed [KEY_W-1:0] rz;
  logic                    hit;
  logic                    evict_now;
  dist_status_t            dstat;

  assign scan_end = (iss == CTR_W'(SLOTS));
  assign cur_idx  = iss[IDX_W-1:0];
  assign in_ready = (state == S_IDLE);
  assign mem_re   = (state == S_SCAN) && !scan_end;
  assign mem_we   = (state == S_ALLOC) && !scan_end && !slot_valid[cur_idx];

  assign hit = (op == OP_LOOKUP) && tag1.vld && slot_valid[tag1.idx] &&
               (rx == kx) && (rz == kz);
  assign evict_now = (state == S_SCAN) && (op == OP_EVICT) && dstat.far &&
                     slot_valid[dstat.tag.idx];

  ctt_coord_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_idx),
    .wx    (kx),
    .wz    (kz),
    .re    (mem_re),
    .raddr (cur_idx),
    .rx    (rx),
    .rz    (rz)
  );

  ctt_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .tag_in (tag1),
    .rx     (rx),
    .rz     (rz),
    .kx     (kx),
    .kz     (kz),
    .r2     (r2),
    .status (dstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cache_radius <= RAD_RESET;
      slot_valid   <= '0;
      loaded_total <= '0;
      tag1.vld     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cache_radius <= cfg_data;
      end
      tag1.vld <= mem_re;
      // in S_FIN the output register is reloaded below instead
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op          <= op_t'(kind);
            kx          <= key_x;
            kz          <= key_z;
            r2          <= R2_W'(cache_radius) * R2_W'(cache_radius);
            iss         <= '0;
            res_found   <= 1'b0;
            res_slot    <= '0;
            res_evicted <= '0;
            case (op_t'(kind))
              OP_LOOKUP, OP_EVICT: state <= S_SCAN;
              OP_ALLOC:            state <= S_ALLOC;
              default:             state <= S_FIN;
            endcase
          end
        end
        S_ALLOC: begin
          if (scan_end) begin
            state <= S_FIN;
          end else if (!slot_valid[cur_idx]) begin
            slot_valid[cur_idx] <= 1'b1;
            if (loaded_total != CTR_W'(SLOTS)) begin
              loaded_total <= loaded_total + 1'b1;
            end
            res_found <= 1'b1;
            res_slot  <= cur_idx;
            state     <= S_FIN;
          end else begin
            iss <= iss + 1'b1;
          end
        end
        S_SCAN: begin
          if (!scan_end) begin
            iss <= iss + 1'b1;
          end
          // first hit wins: slots arrive in ascending order
          if (hit && !res_found) begin
            res_found <= 1'b1;
            res_slot  <= tag1.idx;
          end
          if (evict_now) begin
            slot_valid[dstat.tag.idx] <= 1'b0;
            res_evicted <= res_evicted + 1'b1;
            if (loaded_total != '0) begin
              loaded_total <= loaded_total - 1'b1;
            end
          end
          if (scan_end && !tag1.vld && !dstat.busy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            found         <= res_found;
            slot_index    <= SLOT_W'(res_slot);
            evicted_count <= COUNT_W'(res_evicted);
            loaded_count  <= COUNT_W'(loaded_total);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    tag1.idx <= cur_idx;
  end

endmodule
`default_nettype wire
